// File: hdl/lzfd_pkg.sv
// Shared types and constants for the LZF-style byte decompressor.
// No dependencies; used by lzf_style_byte_decompressor.
`default_nettype none

package lzfd_pkg;

  localparam int unsigned WINDOW   = 131072;
  localparam int unsigned LEN_BITS = 24;
  localparam int unsigned HIST_AW  = $clog2(WINDOW);
  localparam int unsigned BW_W     = HIST_AW + 1;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [LEN_BITS+1:0] lsum_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [HIST_AW-1:0]  haddr_t;
  typedef logic [BW_W-1:0]     bw_t;
  typedef logic [OQ_AW-1:0]    oq_ptr_t;
  typedef logic [OQ_CW-1:0]    oq_cnt_t;

  localparam lsum_t      LEN_SUM_MAX = {2'b00, {LEN_BITS{1'b1}}};
  localparam dist_t      WINDOW_DIST = dist_t'(WINDOW);
  localparam bw_t        WINDOW_BW   = bw_t'(WINDOW);
  localparam logic [12:0] OFF_EXT    = 13'h1FFF;
  localparam logic [2:0] HDR_METHOD  = 3'b001;
  localparam logic [2:0] LEN_EXT     = 3'd7;
  localparam logic [7:0] LEN_CHAIN   = 8'hFF;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CTRL,
    PH_LIT,
    PH_LENX,
    PH_OFF,
    PH_XHI,
    PH_XLO,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_METHOD,
    ERR_BEFORE_START,
    ERR_BEYOND_WINDOW,
    ERR_TRUNCATED,
    ERR_BUSY_COPY,
    ERR_LEN_OVERFLOW
  } err_t;

  typedef struct packed {
    err_t       err;
    logic       pending;
    logic [7:0] data;
    logic       done;
    logic       valid;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/lzf_style_byte_decompressor.sv
// LZF-style byte decompressor: token parser, history RAM, 3-entry result queue.
// Depends on lzfd_pkg and lzfd_ram.
// A result passes through the write-back stage (s1) and the result queue before it is offered on m_*.
// Throughput: one beat per cycle while the queue has room; copy bytes read the history
// RAM and write back in stage s1, forwarding when a copy reads the byte being written.
// Reset clears the parser and queue; the history RAM is not cleared (never read
// before written within a block).
`default_nettype none

module lzf_style_byte_decompressor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // mode
  input  wire logic        s_tlast,   // block_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [7:0] out_byte, [8] copy_pending, [11:9] error_code
  output logic             m_tuser,   // byte_valid
  output logic             m_tlast    // block_done
);

  logic s_fire;
  logic tick;
  logic last;
  logic [7:0] b;

  lzfd_pkg::haddr_t wp, wp_next;
  lzfd_pkg::bw_t    bw, bw_next;
  lzfd_pkg::phase_t phase, phase_next;
  lzfd_pkg::len_t   lit, lit_next, lit_dec;
  lzfd_pkg::len_t   clen, clen_next;
  lzfd_pkg::dist_t  cdist, cdist_next;
  logic             end_seen, end_seen_next;

  lzfd_pkg::lsum_t  lenx_sum;
  lzfd_pkg::dist_t  dist_sum;
  lzfd_pkg::dist_t  dist_ref;

  logic             fail;
  lzfd_pkg::err_t   fail_err;
  logic             fail_ends;
  logic             res_fire;
  logic             res_byte;
  logic             res_ram;
  logic             res_done;
  logic             put;
  lzfd_pkg::result_t res;

  lzfd_pkg::haddr_t raddr;
  logic [7:0]       ram_q;
  logic             fwd;

  logic              s1_valid;
  logic              s1_we;
  logic              s1_use_ram;
  lzfd_pkg::haddr_t  s1_waddr;
  lzfd_pkg::result_t s1_res;
  logic [7:0]        s1_byte;
  lzfd_pkg::result_t s1_out;

  lzfd_pkg::result_t oq_mem [lzfd_pkg::OQ_DEPTH];
  lzfd_pkg::oq_ptr_t oq_wr, oq_rd;
  lzfd_pkg::oq_cnt_t oq_cnt;
  logic              oq_pop;
  lzfd_pkg::result_t oq_head;

  assign s_fire = s_tvalid & s_tready;
  assign tick   = s_tuser;
  assign last   = s_tlast;
  assign b      = s_tdata;

  assign lenx_sum = lzfd_pkg::lsum_t'(lit) + lzfd_pkg::lsum_t'(b) + lzfd_pkg::lsum_t'(2);
  assign dist_sum = cdist + lzfd_pkg::dist_t'(b);
  assign dist_ref = ((phase == lzfd_pkg::PH_OFF) ? dist_sum : dist_sum) + lzfd_pkg::dist_t'(1);
  assign lit_dec  = (lit != '0) ? lit - lzfd_pkg::len_t'(1) : lit;

  always_comb begin
    wp_next       = wp;
    bw_next       = bw;
    phase_next    = phase;
    lit_next      = lit;
    clen_next     = clen;
    cdist_next    = cdist;
    end_seen_next = end_seen;
    fail          = 1'b0;
    fail_err      = lzfd_pkg::ERR_OK;
    fail_ends     = 1'b0;
    res_fire      = 1'b0;
    res_byte      = 1'b0;
    res_ram       = 1'b0;
    res_done      = 1'b0;
    put           = 1'b0;
    if (s_fire) begin
      if (tick) begin
        if (clen != '0) begin
          put       = 1'b1;
          res_fire  = 1'b1;
          res_byte  = 1'b1;
          res_ram   = 1'b1;
          clen_next = clen - lzfd_pkg::len_t'(1);
          if (clen == lzfd_pkg::len_t'(1)) begin
            phase_next    = end_seen ? lzfd_pkg::PH_FIRST : lzfd_pkg::PH_CTRL;
            res_done      = end_seen;
            end_seen_next = 1'b0;
          end
        end
      end else if (clen != '0) begin
        fail      = 1'b1;
        fail_err  = lzfd_pkg::ERR_BUSY_COPY;
        fail_ends = last | end_seen;
      end else begin
        unique case (phase)
          lzfd_pkg::PH_FIRST: begin
            bw_next       = '0;
            end_seen_next = 1'b0;
            if (b[7:5] != lzfd_pkg::HDR_METHOD) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_METHOD;
              fail_ends = last;
            end else if (last) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_TRUNCATED;
              fail_ends = 1'b1;
            end else begin
              lit_next   = lzfd_pkg::len_t'(b[4:0]) + lzfd_pkg::len_t'(1);
              phase_next = lzfd_pkg::PH_LIT;
            end
          end
          lzfd_pkg::PH_CTRL: begin
            if (last) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_TRUNCATED;
              fail_ends = 1'b1;
            end else if (b[7:5] == 3'b000) begin
              lit_next   = lzfd_pkg::len_t'(b) + lzfd_pkg::len_t'(1);
              phase_next = lzfd_pkg::PH_LIT;
            end else begin
              cdist_next = lzfd_pkg::dist_t'({b[4:0], 8'h00});
              lit_next   = lzfd_pkg::len_t'(b[7:5]);
              phase_next = (b[7:5] == lzfd_pkg::LEN_EXT) ? lzfd_pkg::PH_LENX
                                                         : lzfd_pkg::PH_OFF;
            end
          end
          lzfd_pkg::PH_LIT: begin
            if (last && (lit > lzfd_pkg::len_t'(1))) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_TRUNCATED;
              fail_ends = 1'b1;
            end else begin
              put        = 1'b1;
              res_fire   = 1'b1;
              res_byte   = 1'b1;
              lit_next   = lit_dec;
              phase_next = (lit_dec != '0) ? lzfd_pkg::PH_LIT : lzfd_pkg::PH_CTRL;
              if (last) begin
                phase_next = lzfd_pkg::PH_FIRST;
                res_done   = 1'b1;
              end
            end
          end
          lzfd_pkg::PH_LENX: begin
            if (lenx_sum > lzfd_pkg::LEN_SUM_MAX) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_LEN_OVERFLOW;
              fail_ends = last;
            end else if (last) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_TRUNCATED;
              fail_ends = 1'b1;
            end else begin
              lit_next = lit + lzfd_pkg::len_t'(b);
              if (b != lzfd_pkg::LEN_CHAIN) begin
                phase_next = lzfd_pkg::PH_OFF;
              end
            end
          end
          lzfd_pkg::PH_XHI: begin
            if (last) begin
              fail      = 1'b1;
              fail_err  = lzfd_pkg::ERR_TRUNCATED;
              fail_ends = 1'b1;
            end else begin
              cdist_next = cdist + lzfd_pkg::dist_t'({b, 8'h00});
              phase_next = lzfd_pkg::PH_XLO;
            end
          end
          lzfd_pkg::PH_OFF, lzfd_pkg::PH_XLO: begin
            if ((phase == lzfd_pkg::PH_OFF) &&
                (dist_sum == lzfd_pkg::dist_t'(lzfd_pkg::OFF_EXT))) begin
              cdist_next = dist_sum;
              if (last) begin
                fail      = 1'b1;
                fail_err  = lzfd_pkg::ERR_TRUNCATED;
                fail_ends = 1'b1;
              end else begin
                phase_next = lzfd_pkg::PH_XHI;
              end
            end else begin
              cdist_next = dist_ref;
              if (dist_ref > lzfd_pkg::WINDOW_DIST) begin
                fail      = 1'b1;
                fail_err  = lzfd_pkg::ERR_BEYOND_WINDOW;
                fail_ends = last;
              end else if (dist_ref > lzfd_pkg::dist_t'(bw)) begin
                fail      = 1'b1;
                fail_err  = lzfd_pkg::ERR_BEFORE_START;
                fail_ends = last;
              end else begin
                clen_next     = lit + lzfd_pkg::len_t'(2);
                lit_next      = '0;
                end_seen_next = last;
                phase_next    = lzfd_pkg::PH_CTRL;
                res_fire      = 1'b1;
              end
            end
          end
          lzfd_pkg::PH_DROP: begin
            if (last) begin
              phase_next = lzfd_pkg::PH_FIRST;
            end
          end
          default: begin
            phase_next = lzfd_pkg::PH_DROP;
          end
        endcase
      end
      if (put) begin
        wp_next = wp + lzfd_pkg::haddr_t'(1);
        bw_next = (bw < lzfd_pkg::WINDOW_BW) ? bw + lzfd_pkg::bw_t'(1) : bw;
      end
      if (fail) begin
        clen_next     = '0;
        lit_next      = '0;
        end_seen_next = 1'b0;
        phase_next    = fail_ends ? lzfd_pkg::PH_FIRST : lzfd_pkg::PH_DROP;
        res_fire      = 1'b1;
      end
    end
  end

  always_comb begin
    res.err     = fail ? fail_err : lzfd_pkg::ERR_OK;
    res.pending = (clen_next != '0);
    if (res_byte && !res_ram) begin
      res.data = b;
    end else if (res_ram && fwd) begin
      res.data = s1_byte;
    end else begin
      res.data = 8'h00;
    end
    res.done    = fail | res_done;
    res.valid   = res_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      bw       <= '0;
      phase    <= lzfd_pkg::PH_FIRST;
      lit      <= '0;
      clen     <= '0;
      cdist    <= '0;
      end_seen <= 1'b0;
    end else begin
      wp       <= wp_next;
      bw       <= bw_next;
      phase    <= phase_next;
      lit      <= lit_next;
      clen     <= clen_next;
      cdist    <= cdist_next;
      end_seen <= end_seen_next;
    end
  end

  // history read for copy beats; forward the byte being written back this cycle
  assign raddr   = wp - cdist[lzfd_pkg::HIST_AW-1:0];
  assign fwd     = s1_valid && s1_we && (s1_waddr == raddr);
  assign s1_byte = s1_use_ram ? ram_q : s1_res.data;

  always_comb begin
    s1_out      = s1_res;
    s1_out.data = s1_byte;
  end

  lzfd_ram #(
    .WIDTH (8),
    .DEPTH (lzfd_pkg::WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (s1_valid & s1_we),
    .waddr (s1_waddr),
    .wdata (s1_byte),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_fire & res_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_res     <= res;
    s1_we      <= put;
    s1_waddr   <= wp;
    s1_use_ram <= res_ram & ~fwd;
  end

  // result queue; credit counts the beat in the write-back stage
  assign oq_pop   = m_tvalid & m_tready;
  assign s_tready = ((3'(oq_cnt) + 3'(s1_valid)) < 3'(lzfd_pkg::OQ_DEPTH));
  assign m_tvalid = (oq_cnt != '0);
  assign oq_head  = oq_mem[oq_rd];
  assign m_tdata  = {4'h0, oq_head.err, oq_head.pending, oq_head.data};
  assign m_tuser  = oq_head.valid;
  assign m_tlast  = oq_head.done;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq_mem[oq_wr] <= s1_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (s1_valid) begin
        oq_wr <= (oq_wr == lzfd_pkg::oq_ptr_t'(lzfd_pkg::OQ_DEPTH - 1)) ? '0
                 : oq_wr + lzfd_pkg::oq_ptr_t'(1);
      end
      if (oq_pop) begin
        oq_rd <= (oq_rd == lzfd_pkg::oq_ptr_t'(lzfd_pkg::OQ_DEPTH - 1)) ? '0
                 : oq_rd + lzfd_pkg::oq_ptr_t'(1);
      end
      oq_cnt <= oq_cnt + lzfd_pkg::oq_cnt_t'(s1_valid) - lzfd_pkg::oq_cnt_t'(oq_pop);
    end
  end

endmodule

`default_nettype wire

// File: hdl/lzfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module lzfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: verif/lzf_style_byte_decompressor_test.sv
// Self-checking testbench for lzf_style_byte_decompressor: directed and random
// compressed blocks, checked beat by beat against a built-in decoder.
// Depends on lzfd_pkg and the decompressor RTL.
module lzf_style_byte_decompressor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lzfd_pkg::*;

  typedef struct {
    logic [7:0] data;
    bit         valid;
    bit         pending;
    bit         done;
    err_t       err;
  } out_beat_t;

  typedef enum {
    CLEAN, BAD_HEADER, CUT_SHORT, FAR_REFERENCE, BYTE_IN_COPY, STRAY_TICKS, NOISE
  } flaw_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  lzf_style_byte_decompressor dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // decoder state
  logic [7:0]  history_mem [WINDOW];
  haddr_t      wr_ptr      = '0;
  int unsigned out_count   = 0;
  phase_t      parse_phase = PH_FIRST;
  int unsigned lit_left    = 0;
  int unsigned copy_left   = 0;
  int unsigned copy_dist   = 0;
  bit          end_pending = 1'b0;

  out_beat_t   decoded_beats[$];
  out_beat_t   want_beat;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int failures    = 0;
  int beats_sent  = 0;
  int beats_seen  = 0;
  int blocks_sent = 0;
  int err_seen [8];

  int cut_at;
  int block_beats;
  bit block_over;

  function automatic void push_beat(logic [7:0] d, bit v, bit done, err_t e);
    decoded_beats.push_back('{d, v, copy_left != 0, done, e});
  endfunction

  function automatic void store_byte(logic [7:0] d);
    history_mem[wr_ptr] = d;
    wr_ptr++;
    if (out_count < WINDOW) out_count++;
  endfunction

  function automatic void abort_block(err_t e, bit ends);
    copy_left   = 0;
    lit_left    = 0;
    parse_phase = ends ? PH_FIRST : PH_DROP;
    end_pending = 1'b0;
    push_beat(8'h00, 1'b0, 1'b1, e);
  endfunction

  function automatic void close_reference(bit last);
    copy_dist += 1;
    if (copy_dist > WINDOW) abort_block(ERR_BEYOND_WINDOW, last);
    else if (copy_dist > out_count) abort_block(ERR_BEFORE_START, last);
    else begin
      copy_left   = lit_left + 2;
      lit_left    = 0;
      end_pending = last;
      parse_phase = PH_CTRL;
      push_beat(8'h00, 1'b0, 1'b0, ERR_OK);
    end
  endfunction

  function automatic void decode_beat(bit tick, logic [7:0] b, bit last);
    logic [7:0] v;
    bit         done;
    if (tick) begin
      if (copy_left == 0) return;
      v = history_mem[haddr_t'(wr_ptr - copy_dist)];
      store_byte(v);
      copy_left--;
      done = 1'b0;
      if (copy_left == 0) begin
        parse_phase = PH_CTRL;
        if (end_pending) begin
          done        = 1'b1;
          end_pending = 1'b0;
          parse_phase = PH_FIRST;
        end
      end
      push_beat(v, 1'b1, done, ERR_OK);
      return;
    end
    if (copy_left != 0) begin
      abort_block(ERR_BUSY_COPY, last || end_pending);
      return;
    end
    case (parse_phase)
      PH_FIRST: begin
        out_count   = 0;
        end_pending = 1'b0;
        if (b[7:5] != HDR_METHOD) abort_block(ERR_METHOD, last);
        else if (last) abort_block(ERR_TRUNCATED, 1'b1);
        else begin
          lit_left    = b[4:0] + 1;
          parse_phase = PH_LIT;
        end
      end
      PH_CTRL: begin
        if (last) abort_block(ERR_TRUNCATED, 1'b1);
        else if (b < 8'h20) begin
          lit_left    = b + 1;
          parse_phase = PH_LIT;
        end else begin
          copy_dist   = {b[4:0], 8'h00};
          lit_left    = b[7:5];
          parse_phase = (lit_left == LEN_EXT) ? PH_LENX : PH_OFF;
        end
      end
      PH_LIT: begin
        if (last && lit_left > 1) abort_block(ERR_TRUNCATED, 1'b1);
        else begin
          store_byte(b);
          if (lit_left > 0) lit_left--;
          parse_phase = (lit_left != 0) ? PH_LIT : PH_CTRL;
          if (last) parse_phase = PH_FIRST;
          push_beat(b, 1'b1, last, ERR_OK);
        end
      end
      PH_LENX: begin
        if (lit_left + 32'(b) + 2 > 32'(LEN_SUM_MAX)) abort_block(ERR_LEN_OVERFLOW, last);
        else if (last) abort_block(ERR_TRUNCATED, 1'b1);
        else begin
          lit_left += b;
          if (b != LEN_CHAIN) parse_phase = PH_OFF;
        end
      end
      PH_OFF: begin
        copy_dist += b;
        if (copy_dist == 32'(OFF_EXT)) begin
          if (last) abort_block(ERR_TRUNCATED, 1'b1);
          else parse_phase = PH_XHI;
        end else close_reference(last);
      end
      PH_XHI: begin
        if (last) abort_block(ERR_TRUNCATED, 1'b1);
        else begin
          copy_dist  += {b, 8'h00};
          parse_phase = PH_XLO;
        end
      end
      PH_XLO: begin
        copy_dist += b;
        close_reference(last);
      end
      default: if (last) parse_phase = PH_FIRST;
    endcase
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (failures < 40)
      $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (decoded_beats.size() == 0) report_mismatch("unexpected beat", m_tdata, 0);
      else begin
        want_beat = decoded_beats.pop_front();
        err_seen[want_beat.err]++;
        if (m_tdata[7:0] !== want_beat.data)
          report_mismatch("out_byte", m_tdata[7:0], want_beat.data);
        if (m_tuser !== want_beat.valid) report_mismatch("byte_valid", m_tuser, want_beat.valid);
        if (m_tdata[8] !== want_beat.pending)
          report_mismatch("copy_pending", m_tdata[8], want_beat.pending);
        if (m_tlast !== want_beat.done) report_mismatch("block_done", m_tlast, want_beat.done);
        if (m_tdata[11:9] !== want_beat.err)
          report_mismatch("error_code", m_tdata[11:9], want_beat.err);
        if (m_tdata[15:12] !== 4'h0) report_mismatch("tdata pad", m_tdata[15:12], 0);
      end
    end
  end

  task automatic send_beat(bit tick, logic [7:0] b, bit last);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tick;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_beat(tick, b, last);
    beats_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int gap, int stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  task automatic send_bytes(logic [7:0] bytes[], bit last_on_final);
    foreach (bytes[i]) send_beat(1'b0, bytes[i], last_on_final && i == bytes.size() - 1);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(1'b1, 8'($urandom), $urandom_range(1));
  endtask

  // block builder: cut_at forces block_end early for truncation cases
  task automatic in_block(logic [7:0] b, bit last);
    if (block_over) return;
    block_beats++;
    if (block_beats == cut_at) last = 1'b1;
    send_beat(1'b0, b, last);
    if (last) block_over = 1'b1;
  endtask

  task automatic send_literals(int n, bit fin);
    for (int i = 0; i < n && !block_over; i++) in_block(8'($urandom), fin && i == n - 1);
  endtask

  task automatic run_copy(bit interrupt);
    int k;
    k = (copy_left != 0) ? $urandom_range(0, copy_left - 1) : 0;
    while (copy_left != 0) begin
      if (interrupt && k == 0) begin
        interrupt = 1'b0;
        send_beat(1'b0, 8'($urandom), $urandom_range(3) == 0);
        if (s_tlast) block_over = 1'b1;
      end else begin
        send_beat(1'b1, 8'($urandom), $urandom_range(7) == 0);
        k--;
      end
    end
  endtask

  task automatic send_random_block();
    flaw_t       flaw;
    int          r, lits, tokens, len_code, span;
    int unsigned dist_m1;
    logic [7:0]  hdr;
    bit          fin, far_done;
    r = $urandom_range(99);
    flaw = r < 70 ? CLEAN : r < 74 ? BAD_HEADER : r < 80 ? CUT_SHORT : r < 85 ? FAR_REFERENCE :
           r < 90 ? BYTE_IN_COPY : r < 95 ? STRAY_TICKS : NOISE;
    blocks_sent++;
    block_over  = 1'b0;
    block_beats = 0;
    far_done    = 1'b0;
    cut_at      = (flaw == CUT_SHORT) ? $urandom_range(1, 10) : -1;
    if (flaw == NOISE) begin
      repeat ($urandom_range(1, 6))
        send_beat($urandom_range(1), 8'($urandom), $urandom_range(3) == 0);
    end else begin
      tokens = $urandom_range(0, 5);
      lits   = ($urandom_range(9) == 0) ? 31 : $urandom_range(0, 5);
      hdr    = {HDR_METHOD, 5'(lits)};
      if (flaw == BAD_HEADER) begin
        do hdr[7:5] = 3'($urandom); while (hdr[7:5] == HDR_METHOD);
      end
      in_block(hdr, 1'b0);
      send_literals(lits + 1, tokens == 0);
      for (int t = 0; t < tokens && !block_over; t++) begin
        fin = (t == tokens - 1);
        if (flaw == STRAY_TICKS && $urandom_range(1)) send_beat(1'b1, 8'($urandom), 1'b0);
        if ($urandom_range(1)) begin
          lits = ($urandom_range(7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
          in_block(8'(lits), 1'b0);
          send_literals(lits + 1, fin);
        end else begin
          len_code = $urandom_range(1, 7);
          span     = (out_count > 0) ? out_count - 1 : 0;
          if (flaw == FAR_REFERENCE && !far_done) begin
            dist_m1  = out_count + $urandom_range(0, 20);
            far_done = 1'b1;
          end else if ($urandom_range(3) == 0) dist_m1 = $urandom_range(0, span);
          else dist_m1 = $urandom_range(0, span < 7 ? span : 7);
          if (dist_m1 >= 32'(OFF_EXT)) dist_m1 = 32'(OFF_EXT) - 1;
          in_block({3'(len_code), 5'(dist_m1 >> 8)}, 1'b0);
          if (len_code == LEN_EXT) begin
            if ($urandom_range(4) == 0) in_block(LEN_CHAIN, 1'b0);
            in_block(8'($urandom_range(3) == 0 ? $urandom_range(0, 254) : $urandom_range(0, 15)),
                     1'b0);
          end
          in_block(8'(dist_m1), fin);
          run_copy(flaw == BYTE_IN_COPY);
        end
      end
    end
    // bring the decoder back to a block boundary
    while (parse_phase != PH_FIRST || copy_left != 0) begin
      if (copy_left != 0) send_beat(1'b1, 8'($urandom), 1'b0);
      else send_beat(1'b0, 8'($urandom), 1'b1);
    end
  endtask

  task automatic test_header_errors();
    send_bytes('{8'hFF}, 1'b1);
    send_bytes('{8'h00, 8'h55, 8'hAA}, 1'b1);
    send_bytes('{8'h21}, 1'b1);
    drain();
  endtask

  task automatic test_literals_and_copies();
    send_bytes('{8'h21, 8'h00, 8'hFF, 8'h20, 8'h01}, 1'b0);
    send_ticks(4);
    send_bytes('{8'h00, 8'h80}, 1'b1);
    send_bytes('{8'h20, 8'h5A, 8'h40, 8'h00}, 1'b1);
    send_ticks(4);
    drain();
  endtask

  task automatic test_truncation_and_bad_references();
    send_bytes('{8'h22, 8'h01}, 1'b1);
    send_bytes('{8'h20, 8'h00, 8'h3F, 8'hFF, 8'h12}, 1'b1);
    send_bytes('{8'h20, 8'h11, 8'h20, 8'h05, 8'h00}, 1'b1);
    send_bytes('{8'h20, 8'h33, 8'h20, 8'h00}, 1'b1);
    send_ticks(1);
    send_bytes('{8'h21}, 1'b0);
    send_bytes('{8'h20, 8'h44}, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(int gap, int stall, int n);
    int start;
    set_idling(gap, stall);
    start = beats_sent;
    while (beats_sent - start < n) send_random_block();
    drain();
  endtask

  // build past 8 KiB of output so a 0x1FFF-extended offset is in range
  task automatic test_extended_offset();
    send_bytes('{8'h23, 8'h01, 8'h02, 8'h03, 8'h04, 8'hE0}, 1'b0);
    repeat (32) send_beat(1'b0, LEN_CHAIN, 1'b0);
    send_bytes('{8'h10, 8'h00}, 1'b0);
    while (copy_left != 0) send_beat(1'b1, 8'($urandom), 1'b0);
    send_bytes('{8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66}, 1'b0);
    send_bytes('{8'h3F, 8'hFF, 8'h00, 8'h02}, 1'b0);
    send_ticks(3);
    send_bytes('{8'h3F, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b1);
    drain();
  endtask

  task automatic test_length_overflow();
    send_bytes('{8'h20, 8'h00, 8'hE0}, 1'b0);
    while (parse_phase == PH_LENX) send_beat(1'b0, LEN_CHAIN, 1'b0);
    send_bytes('{8'h00}, 1'b1);
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_idling(6, 81);
    test_header_errors();
    test_literals_and_copies();
    test_truncation_and_bad_references();
    test_random_traffic(6, 81, 185);
    test_random_traffic(81, 6, 185);
    test_random_traffic(0, 0, 185);
    test_extended_offset();
    test_length_overflow();
    repeat (20) @(posedge clk);
    $display("Sent %0d input beats in %0d random blocks plus directed cases; checked %0d results.",
             beats_sent, blocks_sent, beats_seen);
    $display("Error results by code: method %0d, before start %0d, truncated %0d, %s %0d, %s %0d",
             err_seen[ERR_METHOD], err_seen[ERR_BEFORE_START], err_seen[ERR_TRUNCATED],
             "byte in copy", err_seen[ERR_BUSY_COPY], "length overflow", err_seen[ERR_LEN_OVERFLOW]);
    if (failures == 0 && decoded_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
